>>> hdl/fcbf_pkg.sv
// Shared types and constants for the flow-controlled byte FIFO.
// No dependencies; imported by flow_controlled_byte_fifo.
package fcbf_pkg;

  // Operation codes carried in the opcode field of an input item.
  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_PEEK  = 3'd2,
    OP_POP   = 3'd3,
    OP_END   = 3'd4
  } fcbf_op_t;

  localparam int          CAP_W       = 7;
  localparam logic [6:0]  CAP_RESET   = 7'd64;
  localparam int          MAX_RESULTS = 64;
  localparam int          TOTAL_W     = 48;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic [6:0] length;
  } fcbf_in_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               last;
    logic               accepted;
    logic [6:0]         buffered;
    logic [6:0]         remaining;
    logic [TOTAL_W-1:0] total_written;
    logic [TOTAL_W-1:0] total_read;
    logic               end_seen;
    logic               at_eof;
  } fcbf_out_t;

endpackage

>>> hdl/flow_controlled_byte_fifo.sv
// Flow-controlled byte FIFO: circular byte store with occupancy and total counters.
// Depends on fcbf_pkg for the item structs, operation codes and constants.
//
// Each item on in_item is one operation, taken when start is high and busy is low.
// Write, pop, end-input and unknown operations give one status result on out_strobe in
// the cycle after the item is taken, and the next item may be taken during that cycle,
// so these run at one item per cycle. Read and peek of n bytes give n results, one byte
// per cycle from the single read port of the byte store, starting the cycle after the
// item is taken; busy stays high until the cycle of the last byte, when the next item
// may be taken (one result if nothing is buffered). The receiver cannot stall: every
// result is shown for exactly one cycle. Every result carries the state after the whole
// operation. The byte store is not cleared after reset; only written bytes are read.
module flow_controlled_byte_fifo #(
  parameter int DEPTH      = 64,
  parameter int COUNT_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  fcbf_pkg::fcbf_in_t   in_item,
  output logic                 out_strobe,
  output fcbf_pkg::fcbf_out_t  out_item,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_wdata
);
  import fcbf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam int IW = EW + 1;
  localparam int TW = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_STATUS = 3'b010,
    ST_STREAM = 3'b100
  } fcbf_state_t;

  fcbf_state_t state_r, state_nxt;

  logic [7:0]            mem [DEPTH];
  logic [7:0]            rdata_r;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [COUNT_BITS-1:0] wtot_r, wtot_nxt;
  logic [COUNT_BITS-1:0] rtot_r, rtot_nxt;
  logic                  ended_r, ended_nxt;
  logic [6:0]            cap_r;
  logic [6:0]            left_r, left_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic                  acc_r, acc_nxt;

  logic                  accept;
  logic                  mem_we;
  logic [AW-1:0]         wr_addr;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [EW-1:0]         count_e, cap_e, effcap, room, len_e, n_e;
  logic [6:0]            n;
  logic                  can_write;
  logic [TW-1:0]         wtot_e, rtot_e;

  // Sum of an index below DEPTH and an offset of at most DEPTH, folded back into the store.
  function automatic logic [AW-1:0] wrap_add(input logic [IW-1:0] s);
    logic [IW-1:0] r;
    r = (s >= IW'(DEPTH)) ? (s - IW'(DEPTH)) : s;
    return r[AW-1:0];
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_r == ST_STREAM) && (left_r > 7'd1);

  always_comb begin
    count_e   = EW'(count_r);
    cap_e     = EW'(cap_r);
    effcap    = (cap_e > EW'(DEPTH)) ? EW'(DEPTH) : cap_e;
    room      = (effcap > count_e) ? (effcap - count_e) : '0;
    can_write = count_e < effcap;
    len_e     = EW'(in_item.length);
    n_e       = (len_e < count_e) ? len_e : count_e;
    if (n_e > EW'(MAX_RESULTS)) begin
      n_e = EW'(MAX_RESULTS);
    end
    n       = n_e[6:0];
    wr_addr = wrap_add(IW'(head_r) + IW'(count_r));
  end

  always_comb begin
    state_nxt = ST_IDLE;
    head_nxt  = head_r;
    count_nxt = count_r;
    wtot_nxt  = wtot_r;
    rtot_nxt  = rtot_r;
    ended_nxt = ended_r;
    left_nxt  = left_r;
    ptr_nxt   = ptr_r;
    acc_nxt   = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = ptr_r;
    if (accept) begin
      state_nxt = ST_STATUS;
      case (in_item.opcode)
        OP_WRITE: begin
          if (can_write) begin
            mem_we    = 1'b1;
            count_nxt = count_r + CW'(1);
            wtot_nxt  = wtot_r + COUNT_BITS'(1);
            acc_nxt   = 1'b1;
          end
        end
        OP_READ, OP_PEEK: begin
          if (n != 7'd0) begin
            state_nxt = ST_STREAM;
            rd_en     = 1'b1;
            rd_addr   = head_r;
            ptr_nxt   = wrap_add(IW'(head_r) + IW'(1));
            left_nxt  = n;
            if (in_item.opcode == OP_READ) begin
              head_nxt  = wrap_add(IW'(head_r) + IW'(n));
              count_nxt = count_r - CW'(n);
              rtot_nxt  = rtot_r + COUNT_BITS'(n);
            end
          end
        end
        OP_POP: begin
          head_nxt  = wrap_add(IW'(head_r) + IW'(n));
          count_nxt = count_r - CW'(n);
          rtot_nxt  = rtot_r + COUNT_BITS'(n);
        end
        OP_END: begin
          ended_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (busy) begin
      // Fetch the next byte of the run while the current one is shown.
      state_nxt = ST_STREAM;
      rd_en     = 1'b1;
      rd_addr   = ptr_r;
      ptr_nxt   = wrap_add(IW'(ptr_r) + IW'(1));
      left_nxt  = left_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_item.data_byte;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      wtot_r  <= '0;
      rtot_r  <= '0;
      ended_r <= 1'b0;
      cap_r   <= CAP_RESET;
      left_r  <= '0;
      ptr_r   <= '0;
      acc_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      wtot_r  <= wtot_nxt;
      rtot_r  <= rtot_nxt;
      ended_r <= ended_nxt;
      left_r  <= left_nxt;
      ptr_r   <= ptr_nxt;
      acc_r   <= acc_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    wtot_e                 = TW'(wtot_r);
    rtot_e                 = TW'(rtot_r);
    out_strobe             = (state_r == ST_STATUS) || (state_r == ST_STREAM);
    out_item.byte_valid    = (state_r == ST_STREAM);
    out_item.out_byte      = (state_r == ST_STREAM) ? rdata_r : 8'd0;
    out_item.last          = (state_r == ST_STATUS) || (left_r == 7'd1);
    out_item.accepted      = (state_r == ST_STATUS) && acc_r;
    out_item.buffered      = count_e[6:0];
    out_item.remaining     = room[6:0];
    out_item.total_written = wtot_e[TOTAL_W-1:0];
    out_item.total_read    = rtot_e[TOTAL_W-1:0];
    out_item.end_seen      = ended_r;
    out_item.at_eof        = ended_r && (count_r == '0);
  end

  // The occupancy can never pass the size of the store.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("byte count exceeds store depth");

  // A stored write raises the occupancy by exactly one.
  a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.opcode == OP_WRITE) && can_write
    |=> count_r == $past(count_r) + CW'(1))
    else $error("accepted write did not raise the byte count");

  // A byte run never continues past its last item without a new operation.
  a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last && !accept |=> state_r != ST_STREAM)
    else $error("byte run continued after its last item");

  // While bytes are being streamed the run length is never zero.
  a_stream_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STREAM) |-> (left_r != 7'd0))
    else $error("streaming with no bytes left");

endmodule
